@@ hdl/wpc_pkg.sv @@
// Package with the shared constants of the sliding window peak counter.
`timescale 1ns / 1ps

package wpc_pkg;

	localparam int unsigned MAX_WINDOW_DEFAULT  = 4096;
	localparam int unsigned MAX_LENGTH_DEFAULT  = 65536;
	localparam int unsigned SAMPLE_BITS_DEFAULT = 16;
	localparam int unsigned COUNT_BITS_DEFAULT  = $clog2(MAX_WINDOW_DEFAULT + 1);
	localparam int unsigned START_BITS_DEFAULT  = $clog2(MAX_LENGTH_DEFAULT + 1);
	localparam int unsigned MIN_WINDOW          = 3;
	localparam int unsigned WINDOW_RESET        = 3;

endpackage

@@ hdl/wpc_sample_if.sv @@
// Interface for the sample channel of the sliding window peak counter.
`timescale 1ns / 1ps

interface wpc_sample_if #(
	parameter int unsigned SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEFAULT
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic                   last_sample;

	modport source (output valid, output sample_value, output last_sample, input ready);
	modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface

@@ hdl/wpc_result_if.sv @@
// Interface for the result channel of the sliding window peak counter.
`timescale 1ns / 1ps

interface wpc_result_if #(
	parameter int unsigned COUNT_BITS = wpc_pkg::COUNT_BITS_DEFAULT,
	parameter int unsigned START_BITS = wpc_pkg::START_BITS_DEFAULT
);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] best_count_plus_one;
	logic [START_BITS-1:0] best_start;

	modport source (output valid, output best_count_plus_one, output best_start, input ready);
	modport sink (input valid, input best_count_plus_one, input best_start, output ready);
endinterface

@@ hdl/window_peak_count_argmax.sv @@
// Top level of the sliding window peak counter with best window search.
`timescale 1ns / 1ps

// The block takes one sample per clock cycle; the last sample of a sequence passes the stage
// one registers and then the result registers. A sample enters a first stage that finds the
// peak flag of the previous sample, writes it into a flag ring RAM and reads the flag that
// leaves the window; the second stage updates the window count and the kept best window.
// The input stalls only when a last sample meets a result that has not been taken yet.
// The window length is latched into the active length at the first sample of each sequence.
module window_peak_count_argmax #(
	parameter int unsigned MAX_WINDOW  = wpc_pkg::MAX_WINDOW_DEFAULT,
	parameter int unsigned MAX_LENGTH  = wpc_pkg::MAX_LENGTH_DEFAULT,
	parameter int unsigned SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [$clog2(MAX_WINDOW + 1)-1:0]    cfg_wdata,
	wpc_sample_if.sink                           samples,
	wpc_result_if.source                         results
);

	localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned AW = $clog2(MAX_WINDOW);
	localparam int unsigned JW = $clog2(MAX_LENGTH + 1);
	localparam int unsigned EW = ((JW > CW) ? JW : CW) + 1;

	logic [CW-1:0]          window_length_q;
	logic [CW-1:0]          active_length_q;
	logic [SAMPLE_BITS-1:0] older_q;
	logic [SAMPLE_BITS-1:0] newer_q;
	logic [JW-1:0]          index_q;
	logic [AW-1:0]          ptr_q;

	logic                   v_s1;
	logic                   last_s1;
	logic                   inr_s1;
	logic                   pk_s1;
	logic                   sub_s1;
	logic                   win_s1;
	logic [JW-1:0]          pos_s1;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          best_q;
	logic [JW-1:0]          bpos_q;

	logic                   out_valid_q;
	logic [CW-1:0]          out_count_q;
	logic [JW-1:0]          out_start_q;

	logic                   accept;
	logic                   out_free;
	logic                   s1_go;
	logic                   in_range;
	logic [CW-1:0]          clamped;
	logic [CW-1:0]          k_cur;
	logic [EW-1:0]          j_ext;
	logic [EW-1:0]          k_ext;
	logic                   peak;
	logic [AW:0]            ra_sum;
	logic [AW-1:0]          raddr;
	logic [AW-1:0]          waddr;
	logic                   ram_we;
	logic                   leave_flag;
	logic [CW-1:0]          count_new;
	logic                   better;
	logic [CW-1:0]          best_new;
	logic [JW-1:0]          bpos_new;

	always_comb begin
		if (window_length_q < CW'(wpc_pkg::MIN_WINDOW)) begin
			clamped = CW'(wpc_pkg::MIN_WINDOW);
		end else if (window_length_q > CW'(MAX_WINDOW)) begin
			clamped = CW'(MAX_WINDOW);
		end else begin
			clamped = window_length_q;
		end
	end

	assign out_free      = !out_valid_q || results.ready;
	assign s1_go         = v_s1 && (!last_s1 || out_free);
	assign samples.ready = !v_s1 || s1_go;
	assign accept        = samples.valid && samples.ready;

	assign in_range = index_q < JW'(MAX_LENGTH);
	assign k_cur    = (index_q == '0) ? clamped : active_length_q;
	assign j_ext    = EW'(index_q);
	assign k_ext    = EW'(k_cur);
	assign peak     = (newer_q > older_q) && (newer_q > samples.sample_value);

	assign ra_sum = {1'b0, ptr_q} + (AW + 1)'(1) + (AW + 1)'(MAX_WINDOW) - (AW + 1)'(k_cur);
	assign raddr  = (ra_sum >= (AW + 1)'(MAX_WINDOW)) ? AW'(ra_sum - (AW + 1)'(MAX_WINDOW))
		: AW'(ra_sum);
	assign waddr  = (ptr_q == '0) ? AW'(MAX_WINDOW - 1) : ptr_q - AW'(1);
	assign ram_we = accept && in_range && (index_q >= JW'(2));

	wpc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WINDOW)
	) u_flag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (peak),
		.re    (accept),
		.raddr (raddr),
		.rdata (leave_flag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= CW'(wpc_pkg::WINDOW_RESET);
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_length_q <= CW'(wpc_pkg::WINDOW_RESET);
			older_q         <= '0;
			newer_q         <= '0;
			index_q         <= '0;
			ptr_q           <= '0;
		end else if (accept) begin
			if (in_range && index_q == '0) begin
				active_length_q <= clamped;
			end
			if (samples.last_sample) begin
				older_q <= '0;
				newer_q <= '0;
				index_q <= '0;
				ptr_q   <= '0;
			end else if (in_range) begin
				older_q <= newer_q;
				newer_q <= samples.sample_value;
				index_q <= index_q + JW'(1);
				ptr_q   <= (ptr_q == AW'(MAX_WINDOW - 1)) ? '0 : ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= samples.last_sample;
			inr_s1  <= in_range;
			pk_s1   <= peak && (index_q >= JW'(2));
			sub_s1  <= j_ext >= k_ext;
			win_s1  <= (j_ext + EW'(1)) >= k_ext;
			pos_s1  <= JW'(j_ext + EW'(1) - k_ext);
		end
	end

	always_comb begin
		count_new = count_q + CW'(pk_s1) - CW'(sub_s1 & leave_flag);
		better    = inr_s1 && win_s1 && (count_new > best_q);
		best_new  = better ? count_new : best_q;
		bpos_new  = better ? pos_s1 : bpos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			best_q  <= '0;
			bpos_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				count_q <= '0;
				best_q  <= '0;
				bpos_q  <= '0;
			end else if (inr_s1) begin
				count_q <= count_new;
				best_q  <= best_new;
				bpos_q  <= bpos_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_count_q <= best_new + CW'(1);
			out_start_q <= bpos_new + JW'(1);
		end
	end

	assign results.valid               = out_valid_q;
	assign results.best_count_plus_one = out_count_q;
	assign results.best_start          = out_start_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_go) |-> (last_s1 && out_valid_q && !results.ready))
		else $error("Stage one stalled without a pending result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (out_valid_q && count_q == '0 && best_q == '0))
		else $error("Sequence state not cleared after a result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ptr_q} < (AW + 1)'(MAX_WINDOW)) && (count_q <= CW'(MAX_WINDOW)))
		else $error("Ring pointer or window count out of range.");

endmodule

@@ hdl/wpc_ram.sv @@
// Generic simple dual port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module wpc_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = wpc_pkg::MAX_WINDOW_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the sliding window peak counter with best window search.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEFAULT;
	localparam int unsigned COUNT_BITS = wpc_pkg::COUNT_BITS_DEFAULT;
	localparam int unsigned START_BITS = wpc_pkg::START_BITS_DEFAULT;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS = 520;

	typedef enum int unsigned {
		VALUES_FULL,
		VALUES_NARROW,
		VALUES_EXTREME,
		VALUES_TOP
	} value_style_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count_plus_one;
		logic [START_BITS-1:0] start;
	} peak_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [COUNT_BITS-1:0] cfg_wdata;

	wpc_sample_if smp ();
	wpc_result_if res ();

	window_peak_count_argmax dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples(smp.sink),
		.results(res.source)
	);

	always #2 clk = ~clk;

	peak_result_t pending_peaks[$];
	int unsigned tx_idle_pct = 12;
	int unsigned rx_idle_pct = 88;
	int unsigned hold_requests = 0;
	int unsigned samples_sent = 0;
	int unsigned error_count = 0;

	int unsigned window_reg = wpc_pkg::WINDOW_RESET;
	int unsigned seq_window = wpc_pkg::WINDOW_RESET;
	int unsigned seq_pos = 0;
	int unsigned peaks_in_window = 0;
	int unsigned best_peaks = 0;
	int unsigned best_offset = 0;
	logic [SAMPLE_BITS-1:0] older_val = '0;
	logic [SAMPLE_BITS-1:0] newer_val = '0;
	bit peak_ring [wpc_pkg::MAX_WINDOW_DEFAULT];

	function automatic bit predict_peak_result(input logic [SAMPLE_BITS-1:0] value,
			input logic is_last, output peak_result_t result);
		bit is_peak;
		result = '0;
		if (seq_pos < wpc_pkg::MAX_LENGTH_DEFAULT) begin
			if (seq_pos == 0) begin
				if (window_reg < wpc_pkg::MIN_WINDOW)
					seq_window = wpc_pkg::MIN_WINDOW;
				else if (window_reg > wpc_pkg::MAX_WINDOW_DEFAULT)
					seq_window = wpc_pkg::MAX_WINDOW_DEFAULT;
				else
					seq_window = window_reg;
			end
			if (seq_pos >= 2) begin
				is_peak = (newer_val > older_val) && (newer_val > value);
				peak_ring[(seq_pos - 1) % wpc_pkg::MAX_WINDOW_DEFAULT] = is_peak;
				peaks_in_window += is_peak;
			end
			if (seq_pos >= seq_window)
				peaks_in_window -=
					peak_ring[(seq_pos + 1 - seq_window) % wpc_pkg::MAX_WINDOW_DEFAULT];
			if (seq_pos + 1 >= seq_window && peaks_in_window > best_peaks) begin
				best_peaks = peaks_in_window;
				best_offset = seq_pos + 1 - seq_window;
			end
			older_val = newer_val;
			newer_val = value;
			seq_pos++;
		end
		if (!is_last)
			return 1'b0;
		result.count_plus_one = COUNT_BITS'(best_peaks + 1);
		result.start = START_BITS'(best_offset + 1);
		older_val = '0;
		newer_val = '0;
		seq_pos = 0;
		peaks_in_window = 0;
		best_peaks = 0;
		best_offset = 0;
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] make_value(input value_style_t style);
		case (style)
			VALUES_NARROW: return SAMPLE_BITS'($urandom_range(3));
			VALUES_EXTREME: return $urandom_range(1) ? '1 : '0;
			VALUES_TOP: return SAMPLE_BITS'($urandom_range(65535, 65532));
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic is_last);
		peak_result_t result;
		if ($urandom_range(99) < tx_idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.sample_value <= value;
		smp.last_sample <= is_last;
		@(posedge clk);
		while (smp.ready !== 1'b1)
			@(posedge clk);
		if (predict_peak_result(value, is_last, result))
			pending_peaks.insert(pending_peaks.size(), result);
		samples_sent++;
	endtask

	task automatic send_sequence(input int unsigned len, input value_style_t style);
		for (int unsigned i = 0; i < len; i++)
			send_sample(make_value(style), i == len - 1);
	endtask

	task automatic settle_block();
		smp.valid <= 1'b0;
		while (pending_peaks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input int unsigned value);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= COUNT_BITS'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		window_reg = value;
	endtask

	task automatic test_short_sequences();
		send_sample(16'h1234, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		for (int i = 0; i < 4; i++)
			send_sample(16'd7, i == 3);
		for (int i = 0; i < 7; i++)
			send_sample((i == 3 || i == 5) ? 16'd5 : 16'd0, i == 6);
	endtask

	task automatic test_window_limits();
		set_window(0);
		send_sequence(6, VALUES_EXTREME);
		set_window(1);
		send_sequence(6, VALUES_NARROW);
		set_window(2);
		send_sequence(7, VALUES_TOP);
		set_window(4);
		send_sequence(9, VALUES_NARROW);
		set_window(4097);
		send_sequence(20, VALUES_FULL);
		tx_idle_pct = 0;
		set_window(wpc_pkg::MAX_WINDOW_DEFAULT);
		send_sequence(40, VALUES_NARROW);
		set_window(8191);
		send_sequence(40, VALUES_EXTREME);
		tx_idle_pct = 12;
		// The register is latched by the first item of a sequence.
		set_window(3);
		for (int i = 0; i < 4; i++)
			send_sample(make_value(VALUES_NARROW), 1'b0);
		set_window(6);
		send_sequence(7, VALUES_NARROW);
		send_sequence(12, VALUES_NARROW);
	endtask

	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 12;
		set_window(3);
		hold_requests++;
		for (int i = 0; i < 40; i++)
			send_sequence($urandom_range(4, 1), value_style_t'($urandom_range(3)));
		settle_block();
	endtask

	task automatic test_random_sequences(input int unsigned tx_pct, input int unsigned rx_pct);
		int unsigned first;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		first = samples_sent;
		while (samples_sent - first < PHASE_ITEMS) begin
			if ($urandom_range(9) == 0)
				set_window(($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(16));
			send_sequence(($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(40, 1),
				value_style_t'($urandom_range(3)));
		end
	endtask

	initial begin
		int unsigned hold_served;
		int unsigned hold_left;
		hold_served = 0;
		hold_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		peak_result_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_peaks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual count_plus_one=%0d start=%0d",
					$time, res.best_count_plus_one, res.best_start);
				error_count++;
			end else begin
				want = pending_peaks[0];
				pending_peaks.delete(0);
				if (res.best_count_plus_one !== want.count_plus_one) begin
					$display("%0t: best_count_plus_one expected %0d actual %0d",
						$time, want.count_plus_one, res.best_count_plus_one);
					error_count++;
				end
				if (res.best_start !== want.start) begin
					$display("%0t: best_start expected %0d actual %0d",
						$time, want.start, res.best_start);
					error_count++;
				end
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
					(res.valid === 1'b1 && res.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		smp.valid <= 1'b0;
		smp.sample_value <= '0;
		smp.last_sample <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_sequences();
		test_window_limits();
		test_output_backpressure();
		test_random_sequences(12, 88);
		test_random_sequences(88, 12);
		test_random_sequences(0, 0);
		settle_block();
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
